// ===== hw/rtl/tofh_pkg.sv =====
// tofh_pkg: shared widths, reset values and codes of the time-of-flight histogram unit
// no dependencies; imported by every module of the unit

package tofh_pkg;

  // default depth of the bin memory
  localparam int unsigned NUM_BINS_DEF = 4096;

  // field widths
  localparam int unsigned CODE_W  = 8;
  localparam int unsigned TIME_W  = 24;
  localparam int unsigned BW_W    = 16;
  localparam int unsigned BIU_W   = 13;
  localparam int unsigned IDX_W   = 12;
  localparam int unsigned CNT_W   = 32;
  localparam int unsigned CFG_A_W = 2;
  localparam int unsigned CFG_D_W = 16;

  // register reset values
  localparam logic [CODE_W-1:0] RST_CODE  = 8'd4;
  localparam logic [BW_W-1:0]   RST_WIDTH = 16'd32;
  localparam logic [BIU_W-1:0]  RST_BINS  = 13'd4032;

  // configuration register indexes
  localparam logic [CFG_A_W-1:0] CFG_CODE  = 2'd0;
  localparam logic [CFG_A_W-1:0] CFG_WIDTH = 2'd1;
  localparam logic [CFG_A_W-1:0] CFG_BINS  = 2'd2;

  // result status codes
  typedef enum logic [1:0] {
    ST_COUNTED  = 2'd0,
    ST_REJECTED = 2'd1,
    ST_RANGE    = 2'd2,
    ST_READ     = 2'd3
  } status_e;

endpackage

// ===== hw/rtl/tof_event_histogram_unit.sv =====
// tof_event_histogram_unit: top level, request sequencer and configuration registers
// depends on tofh_pkg, tofh_divider and tofh_bin_mem
//
//  channel   | handshake                  | payload
//  ----------+----------------------------+------------------------------------------
//  request   | start, busy                | opcode_i, event_code_i, flight_time_i,
//            |                            | read_bin_i
//  result    | result_valid_o (1 cycle)   | status_o, bin_index_o, bin_count_o
//  config    | cfg_we_i                   | cfg_idx_i, cfg_wdata_i
//
// a counted record goes through the one-bit-per-cycle divider, the bin read and
// the write-back before its result; a record dropped for range returns after the
// divide, a bin read after the memory read, and a rejected record, a zero-width
// drop or a read beyond the memory is answered straight from the idle state
// after reset busy stays high while the memory is cleared
// one request in flight at a time; the receiver takes every result when shown

module tof_event_histogram_unit
  import tofh_pkg::*;
#(
  parameter int unsigned NUM_BINS = NUM_BINS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // request
  input  logic               start,
  output logic               busy,
  input  logic               opcode_i,
  input  logic [CODE_W-1:0]  event_code_i,
  input  logic [TIME_W-1:0]  flight_time_i,
  input  logic [IDX_W-1:0]   read_bin_i,
  // result
  output logic               result_valid_o,
  output logic [1:0]         status_o,
  output logic [IDX_W-1:0]   bin_index_o,
  output logic [CNT_W-1:0]   bin_count_o,
  // configuration
  input  logic               cfg_we_i,
  input  logic [CFG_A_W-1:0] cfg_idx_i,
  input  logic [CFG_D_W-1:0] cfg_wdata_i
);

  localparam int unsigned AW    = $clog2(NUM_BINS);
  localparam int unsigned LIM_W = TIME_W + 1;
  localparam logic [LIM_W-1:0] NUM_BINS_L = LIM_W'(NUM_BINS);
  localparam logic [AW-1:0]    LAST_ADDR  = AW'(NUM_BINS - 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV,
    S_UPDATE,
    S_READ
  } state_e;

  state_e            state_q;
  logic [AW-1:0]     clr_q;
  logic [IDX_W-1:0]  rbin_q;
  logic              valid_q;
  status_e           status_q;
  logic [IDX_W-1:0]  idx_q;
  logic [CNT_W-1:0]  cnt_q;

  logic [CODE_W-1:0] code_q;
  logic [BW_W-1:0]   width_q;
  logic [BIU_W-1:0]  bins_q;

  logic              accept;
  logic              div_start;
  logic              div_done;
  logic [TIME_W-1:0] quotient;
  logic [LIM_W-1:0]  bins_ext;
  logic [LIM_W-1:0]  limit;
  logic              bin_ok;
  logic              rbin_ok;
  logic [TIME_W-1:0] rbin_ext;
  logic [CNT_W-1:0]  rdata;
  logic [CNT_W-1:0]  cnt_inc;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [CNT_W-1:0]  mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_q  <= RST_CODE;
      width_q <= RST_WIDTH;
      bins_q  <= RST_BINS;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_CODE:  code_q  <= cfg_wdata_i[CODE_W-1:0];
        CFG_WIDTH: width_q <= cfg_wdata_i[BW_W-1:0];
        CFG_BINS:  bins_q  <= cfg_wdata_i[BIU_W-1:0];
        default: ;
      endcase
    end
  end

  // range checks
  assign bins_ext = {{(LIM_W-BIU_W){1'b0}}, bins_q};
  assign limit    = (bins_ext > NUM_BINS_L) ? NUM_BINS_L : bins_ext;
  assign bin_ok   = {1'b0, quotient} < limit;
  assign rbin_ext = {{(TIME_W-IDX_W){1'b0}}, read_bin_i};
  assign rbin_ok  = {1'b0, rbin_ext} < NUM_BINS_L;

  // saturating increment
  assign cnt_inc = (&rdata) ? rdata : rdata + 1'b1;

  assign accept    = start && (state_q == S_IDLE);
  assign div_start = accept && !opcode_i && (event_code_i == code_q) && (width_q != '0);

  // memory access steering
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_q;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = rbin_ext[AW-1:0];
    unique case (state_q)
      S_CLEAR: begin
        mem_we = 1'b1;
      end
      S_IDLE: begin
        mem_re = accept && opcode_i && rbin_ok;
      end
      S_DIV: begin
        mem_re    = div_done && bin_ok;
        mem_raddr = quotient[AW-1:0];
      end
      S_UPDATE: begin
        mem_we    = 1'b1;
        mem_waddr = quotient[AW-1:0];
        mem_wdata = cnt_inc;
      end
      default: ;
    endcase
  end

  // sequencer and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      clr_q    <= '0;
      valid_q  <= 1'b0;
      status_q <= ST_COUNTED;
      idx_q    <= '0;
      cnt_q    <= '0;
      rbin_q   <= '0;
    end else begin
      valid_q <= 1'b0;
      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == LAST_ADDR) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            rbin_q <= read_bin_i;
            priority if (opcode_i) begin
              if (rbin_ok) begin
                state_q <= S_READ;
              end else begin
                valid_q  <= 1'b1;
                status_q <= ST_READ;
                idx_q    <= read_bin_i;
                cnt_q    <= '0;
              end
            end else if (event_code_i != code_q) begin
              valid_q  <= 1'b1;
              status_q <= ST_REJECTED;
              idx_q    <= '0;
              cnt_q    <= '0;
            end else if (width_q == '0) begin
              valid_q  <= 1'b1;
              status_q <= ST_RANGE;
              idx_q    <= '0;
              cnt_q    <= '0;
            end else begin
              state_q <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            if (bin_ok) begin
              state_q <= S_UPDATE;
            end else begin
              state_q  <= S_IDLE;
              valid_q  <= 1'b1;
              status_q <= ST_RANGE;
              idx_q    <= '0;
              cnt_q    <= '0;
            end
          end
        end
        S_UPDATE: begin
          state_q  <= S_IDLE;
          valid_q  <= 1'b1;
          status_q <= ST_COUNTED;
          idx_q    <= quotient[IDX_W-1:0];
          cnt_q    <= cnt_inc;
        end
        S_READ: begin
          state_q  <= S_IDLE;
          valid_q  <= 1'b1;
          status_q <= ST_READ;
          idx_q    <= rbin_q;
          cnt_q    <= rdata;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  tofh_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (flight_time_i),
    .divisor_i  (width_q),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  tofh_bin_mem #(
    .DEPTH (NUM_BINS)
  ) u_bin_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (rdata)
  );

  assign busy           = (state_q != S_IDLE);
  assign result_valid_o = valid_q;
  assign status_o       = status_q;
  assign bin_index_o    = idx_q;
  assign bin_count_o    = cnt_q;

endmodule

// ===== hw/rtl/tofh_divider.sv =====
// tofh_divider: radix-2 restoring divider, flight time over bin width
// depends on tofh_pkg for the operand widths

module tofh_divider
  import tofh_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [TIME_W-1:0] dividend_i,
  input  logic [BW_W-1:0]   divisor_i,
  output logic              done_o,
  output logic [TIME_W-1:0] quotient_o
);

  localparam int unsigned STEP_W = $clog2(TIME_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(TIME_W - 1);

  logic              busy_q;
  logic              done_q;
  logic [STEP_W-1:0] step_q;
  logic [TIME_W-1:0] quo_q, quo_d;
  logic [BW_W-1:0]   div_q;
  logic [BW_W-1:0]   rem_q, rem_d;
  logic [BW_W:0]     rem_sh;
  logic [BW_W:0]     rem_diff;

  // one quotient bit per cycle; dividend bits shift out at the top
  always_comb begin
    rem_sh   = {rem_q, quo_q[TIME_W-1]};
    rem_diff = rem_sh - {1'b0, div_q};
    if (!rem_diff[BW_W]) begin
      rem_d = rem_diff[BW_W-1:0];
      quo_d = {quo_q[TIME_W-2:0], 1'b1};
    end else begin
      rem_d = rem_sh[BW_W-1:0];
      quo_d = {quo_q[TIME_W-2:0], 1'b0};
    end
  end

  // iteration control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 1'b1;
        if (step_q == LAST_STEP) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ===== hw/rtl/tofh_bin_mem.sv =====
// tofh_bin_mem: bin counter memory, one write and one registered read port
// depends on tofh_pkg for the counter width

module tofh_bin_mem
  import tofh_pkg::*;
#(
  parameter int unsigned DEPTH = NUM_BINS_DEF,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [CNT_W-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [CNT_W-1:0] rdata_o
);

  logic [CNT_W-1:0] mem_q [DEPTH];
  logic [CNT_W-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, registered output
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// tb: self-checking testbench of the time-of-flight histogram unit
// depends on tofh_pkg and tof_event_histogram_unit; predicts every result in place

module tb;
  import tofh_pkg::*;

  localparam int unsigned BIN_DEPTH   = NUM_BINS_DEF;
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned MAX_REPORTS = 20;
  localparam int unsigned DRAIN_WAIT  = 40;
  localparam logic        OP_RECORD   = 1'b0;
  localparam logic        OP_READ     = 1'b1;
  localparam logic [CFG_A_W-1:0] CFG_SPARE = 2'd3;
  localparam logic [TIME_W-1:0]  TIME_MAX  = '1;

  typedef struct packed {
    logic              opcode;
    logic [CODE_W-1:0] event_code;
    logic [TIME_W-1:0] flight_time;
    logic [IDX_W-1:0]  read_bin;
  } request_t;

  typedef struct packed {
    status_e          status;
    logic [IDX_W-1:0] bin_index;
    logic [CNT_W-1:0] bin_count;
  } result_t;

  // clock, reset and block inputs, all known from time zero
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic start  = 1'b0;
  request_t cur_request = '0;
  logic               cfg_we_i    = 1'b0;
  logic [CFG_A_W-1:0] cfg_idx_i   = '0;
  logic [CFG_D_W-1:0] cfg_wdata_i = '0;

  logic             busy;
  logic             result_valid_o;
  logic [1:0]       status_o;
  logic [IDX_W-1:0] bin_index_o;
  logic [CNT_W-1:0] bin_count_o;

  // predicted histogram and register copies
  logic [CNT_W-1:0] bin_counts [BIN_DEPTH];
  logic [CODE_W-1:0] accept_code;
  logic [BW_W-1:0]   bin_w;
  logic [BIU_W-1:0]  bins_used;

  request_t    pending_requests [$];
  result_t     expected_results [$];
  int unsigned hot_bins [8];
  int unsigned sender_idle_pct = 0;
  int unsigned mismatches      = 0;
  int unsigned cycle_count     = 0;

  always #4 clk_i = ~clk_i;

  tof_event_histogram_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .opcode_i       (cur_request.opcode),
    .event_code_i   (cur_request.event_code),
    .flight_time_i  (cur_request.flight_time),
    .read_bin_i     (cur_request.read_bin),
    .result_valid_o (result_valid_o),
    .status_o       (status_o),
    .bin_index_o    (bin_index_o),
    .bin_count_o    (bin_count_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  // number of bins that can count, after clamping to the memory depth
  function automatic int unsigned bins_limit();
    return (bins_used > BIN_DEPTH) ? BIN_DEPTH : int'(bins_used);
  endfunction

  // highest bin a 24-bit flight time can reach at the current width
  function automatic int unsigned top_bin();
    return (bin_w == 0) ? 0 : int'(TIME_MAX) / int'(bin_w);
  endfunction

  // expected result of one request, updating the predicted histogram
  function automatic result_t histogram_apply(input request_t req);
    result_t     res;
    int unsigned bin;
    res.status    = ST_RANGE;
    res.bin_index = '0;
    res.bin_count = '0;
    if (req.opcode == OP_READ) begin
      res.status    = ST_READ;
      res.bin_index = req.read_bin;
      if (req.read_bin < BIN_DEPTH) res.bin_count = bin_counts[req.read_bin];
    end else if (req.event_code != accept_code) begin
      res.status = ST_REJECTED;
    end else if (bin_w != 0) begin
      bin = req.flight_time / bin_w;
      if (bin < bins_limit()) begin
        // counter saturates at all ones but still reports counted
        if (bin_counts[bin] != '1) bin_counts[bin] = bin_counts[bin] + 1'b1;
        res.status    = ST_COUNTED;
        res.bin_index = IDX_W'(bin);
        res.bin_count = bin_counts[bin];
      end
    end
    return res;
  endfunction

  // random request shaped by the current setting: mostly matching records
  // aimed at a few busy bins and at the range edge, some reads, some noise
  function automatic request_t random_request();
    request_t    req;
    int unsigned roll, lim, bin, t;
    req.opcode      = OP_RECORD;
    req.event_code  = CODE_W'($urandom);
    req.flight_time = TIME_W'($urandom);
    req.read_bin    = IDX_W'($urandom);
    roll = $urandom_range(99);
    lim  = bins_limit();
    if (roll < 20) begin
      req.opcode = OP_READ;
      if ($urandom_range(2) != 0) req.read_bin = IDX_W'(hot_bins[$urandom_range(7)]);
    end else begin
      if (roll < 85) req.event_code = accept_code;
      if (bin_w != 0 && lim != 0 && $urandom_range(4) != 0) begin
        case ($urandom_range(3))
          0:       bin = lim;
          1:       bin = lim - 1;
          default: bin = hot_bins[$urandom_range(7)];
        endcase
        if (bin <= top_bin()) begin
          t = bin * bin_w + $urandom_range(bin_w - 1);
          req.flight_time = (t > TIME_MAX) ? TIME_MAX : TIME_W'(t);
        end
      end
    end
    return req;
  endfunction

  // register copies follow the write port
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      accept_code <= RST_CODE;
      bin_w       <= RST_WIDTH;
      bins_used   <= RST_BINS;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CODE:  accept_code <= cfg_wdata_i[CODE_W-1:0];
        CFG_WIDTH: bin_w       <= cfg_wdata_i[BW_W-1:0];
        CFG_BINS:  bins_used   <= cfg_wdata_i[BIU_W-1:0];
        default: ;
      endcase
    end
  end

  // request driver: predicts on acceptance, then offers the next request
  always @(posedge clk_i) begin : request_driver
    if (!rst_ni) begin
      start <= 1'b0;
      foreach (bin_counts[i]) bin_counts[i] = '0;
    end else begin
      if (start && !busy)
        expected_results.insert(expected_results.size(), histogram_apply(cur_request));
      if (!start || !busy) begin
        if (pending_requests.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          cur_request <= pending_requests.pop_front();
          start       <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input logic [CNT_W-1:0] exp_v,
                             input logic [CNT_W-1:0] act_v);
    if (exp_v !== act_v) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
    end
  endtask

  // result monitor: every strobe is compared with the oldest prediction
  always @(posedge clk_i) begin : result_monitor
    result_t want;
    if (rst_ni && result_valid_o !== 1'b0) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected result, expected none, got status %0h bin %0h count %0h",
                   $time, status_o, bin_index_o, bin_count_o);
      end else begin
        want = expected_results.pop_front();
        check_field("status", CNT_W'(want.status), CNT_W'(status_o));
        check_field("bin_index", CNT_W'(want.bin_index), CNT_W'(bin_index_o));
        check_field("bin_count", want.bin_count, bin_count_o);
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_A_W-1:0] idx, input logic [CFG_D_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // all registers plus the unused index; unused upper data bits toggle too
  task automatic set_config(input logic [CODE_W-1:0] code, input logic [BW_W-1:0] width,
                            input logic [CFG_D_W-1:0] bins_val);
    write_reg(CFG_CODE, {8'($urandom), code});
    write_reg(CFG_WIDTH, width);
    write_reg(CFG_BINS, bins_val);
    write_reg(CFG_SPARE, CFG_D_W'($urandom));
    @(posedge clk_i);
  endtask

  // pick the bins that records pile into during one setting
  task automatic new_hot_bins();
    int unsigned span;
    span = bins_limit();
    if (bin_w != 0 && top_bin() + 1 < span) span = top_bin() + 1;
    foreach (hot_bins[i])
      hot_bins[i] = (span == 0) ? $urandom_range(BIN_DEPTH - 1) : $urandom_range(span - 1);
    if (span != 0) begin
      hot_bins[0] = 0;
      hot_bins[1] = span - 1;
    end
  endtask

  task automatic push_record(input logic [CODE_W-1:0] code, input logic [TIME_W-1:0] t);
    request_t req;
    req = '{OP_RECORD, code, t, IDX_W'($urandom)};
    pending_requests.insert(pending_requests.size(), req);
  endtask

  task automatic push_read(input logic [IDX_W-1:0] bin);
    request_t req;
    req = '{OP_READ, CODE_W'($urandom), TIME_W'($urandom), bin};
    pending_requests.insert(pending_requests.size(), req);
  endtask

  // wait until every request is taken and every result has come back;
  // sampled mid-cycle so the edge's updates have all settled
  task automatic drain();
    do @(negedge clk_i);
    while (pending_requests.size() != 0 || start || expected_results.size() != 0);
  endtask

  // stimulus sequence
  initial begin
    logic [CODE_W-1:0]  code;
    logic [BW_W-1:0]    width;
    logic [CFG_D_W-1:0] bins_val;
    int unsigned        count;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset setting, bin edges, range edge, rejected codes, bin reads
    push_record(8'd4, 24'd0);
    push_record(8'd4, 24'd31);
    push_record(8'd4, 24'd32);
    push_record(8'd4, 24'd129023);
    push_record(8'd4, 24'd129024);
    push_record(8'd4, TIME_MAX);
    push_record(8'd3, 24'd0);
    push_record(8'd255, 24'd0);
    push_record(8'd0, 24'd64);
    push_read(12'd0);
    push_read(12'd1);
    push_read(12'd4031);
    push_read(12'd4032);
    push_read(12'hFFF);
    drain();

    // widest range, narrowest bins
    set_config(8'd255, 16'd1, 16'd4096);
    push_record(8'd255, 24'd4095);
    push_record(8'd255, 24'd4096);
    push_read(12'hFFF);
    drain();

    // zero bin width drops matching records
    set_config(8'd0, 16'd0, 16'd1);
    push_record(8'd0, 24'd0);
    push_record(8'd1, 24'd0);
    drain();

    // bins in use beyond the memory depth clamp to it
    set_config(8'd0, 16'hFFFF, 16'd8191);
    push_record(8'd0, TIME_MAX);
    drain();

    // no bins in use drops everything
    set_config(8'd0, 16'd16, 16'd0);
    push_record(8'd0, 24'd0);
    drain();

    // a single bin
    set_config(8'd0, 16'd16, 16'd1);
    push_record(8'd0, 24'd15);
    push_record(8'd0, 24'd16);
    drain();

    // random settings with changing sender gaps
    for (int ph = 0; ph < 8; ph++) begin
      code  = CODE_W'($urandom);
      count = 210;
      case (ph)
        0: begin width = 16'd32; bins_val = 16'd4032; sender_idle_pct = 0; end
        1: begin code = 8'd0; width = 16'd1; bins_val = 16'd4096; sender_idle_pct = 86; end
        2: begin code = 8'd255; width = 16'hFFFF; bins_val = 16'hFFFF; sender_idle_pct = 8; end
        3: begin
          width = $urandom_range(65535, 1); bins_val = $urandom_range(4096, 1);
          sender_idle_pct = 0;
        end
        4: begin width = 16'd4096; bins_val = 16'd4096; sender_idle_pct = 86; end
        5: begin
          width = $urandom_range(300, 1); bins_val = $urandom_range(64, 1);
          sender_idle_pct = 8;
        end
        6: begin
          width = 16'd0; bins_val = CFG_D_W'($urandom); sender_idle_pct = 0; count = 60;
        end
        default: begin
          width = $urandom_range(2000, 1); bins_val = $urandom_range(8191, 4097);
          sender_idle_pct = 86;
        end
      endcase
      set_config(code, width, bins_val);
      new_hot_bins();
      repeat (count) pending_requests.insert(pending_requests.size(), random_request());
      drain();
    end

    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
